>>> hw/rtl/resizable_capacity_stack_top_defines.svh
// Assertion macros used by the checker file of the resizable stack.
// Depends on nothing; all need i_clk in scope, RCS_ASSERT also i_rst_n.
`ifndef RESIZABLE_CAPACITY_STACK_TOP_DEFINES_SVH
`define RESIZABLE_CAPACITY_STACK_TOP_DEFINES_SVH

// Checked on every rising edge outside reset.
`define RCS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define RCS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> hw/rtl/rcs_pkg.sv
// Package of the resizable-capacity stack: sizes, word type, operation codes
// and the capacity clamp. Used by the top level and its checker.
package rcs_pkg;

    localparam int MAX_CAPACITY = 1024;
    localparam int DATA_WIDTH   = 32;
    localparam int ADDR_W       = $clog2(MAX_CAPACITY);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int CMP_W        = CNT_W + 3;

    localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'(MAX_CAPACITY);
    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(10);

    typedef logic signed [DATA_WIDTH-1:0] t_word;
    typedef logic [CNT_W-1:0]             t_count;
    typedef logic [ADDR_W-1:0]            t_addr;
    typedef logic [CMP_W-1:0]             t_cmp;

    typedef enum logic {
        KIND_PUSH = 1'b0,
        KIND_POP  = 1'b1
    } t_kind;

    // A requested size of zero means one; anything above the memory depth
    // is held at the depth.
    function automatic t_count cap_clamp(input t_count c);
        t_count r;
        if (c == '0) begin
            r = CNT_W'(1);
        end else if (c > CAP_MAX) begin
            r = CAP_MAX;
        end else begin
            r = c;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/resizable_capacity_stack_top.sv
// Resizable-capacity LIFO stack of signed 32-bit words in a 1024-entry memory. One push or
// pop is accepted per cycle unless the output stalls or a configuration is written, which
// restarts the stack empty with the new capacity. The result is presented in the output
// register on the next cycle; the single memory port takes one access per item, which
// sets that rate. A push is refused when the stack is full to its logical capacity; a pop
// on an empty stack returns 0 and is flagged not accepted. After each accepted operation
// the capacity grows by half (capped at the depth) when the fill reaches four fifths of
// it, and otherwise halves when the fill is down to a fifth, but only once it has grown.
module resizable_capacity_stack_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_kind,
    input  logic signed [31:0]              i_value,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [31:0]              o_pop_value,
    output logic                            o_accepted,
    output logic [10:0]                     o_capacity,
    output logic [10:0]                     o_occupancy,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [10:0]                     i_cfg_initial_capacity
);

    rcs_pkg::t_word  r_mem [rcs_pkg::MAX_CAPACITY];
    rcs_pkg::t_word  r_rd_data;

    rcs_pkg::t_count r_fill, n_fill;
    rcs_pkg::t_count r_cap, n_cap;
    logic            r_grown, n_grown;

    logic            r_out_valid;
    logic            r_accepted;
    logic            r_pop_ok;
    rcs_pkg::t_count r_out_cap;
    rcs_pkg::t_count r_out_occ;

    logic            in_beat;
    logic            cfg_beat;
    logic            push_ok;
    logic            pop_ok;
    rcs_pkg::t_count op_fill;
    rcs_pkg::t_cmp   fill_x5;
    rcs_pkg::t_cmp   cap_x4;
    logic            grow_hit;
    logic            shrink_hit;
    logic [rcs_pkg::CNT_W:0] grown_sum;
    rcs_pkg::t_count grown_cap;
    rcs_pkg::t_addr  push_addr;
    rcs_pkg::t_addr  pop_addr;

    assign o_cfg_ready = 1'b1;
    assign cfg_beat    = i_cfg_valid;
    assign o_in_ready  = (!r_out_valid || i_out_ready) && !i_cfg_valid;
    assign in_beat     = i_in_valid && o_in_ready;

    always_comb begin
        push_ok = in_beat && (i_kind == rcs_pkg::KIND_PUSH)
                  && (r_fill < r_cap) && (r_fill < rcs_pkg::CAP_MAX);
        pop_ok  = in_beat && (i_kind == rcs_pkg::KIND_POP) && (r_fill != '0);

        if (push_ok) begin
            op_fill = r_fill + rcs_pkg::CNT_W'(1);
        end else if (pop_ok) begin
            op_fill = r_fill - rcs_pkg::CNT_W'(1);
        end else begin
            op_fill = r_fill;
        end

        // fill >= floor(4*cap/5) is the same as 4*cap <= 5*fill + 4, and
        // fill <= floor(cap/5) is the same as 5*fill <= cap.
        fill_x5    = rcs_pkg::CMP_W'(op_fill) + rcs_pkg::CMP_W'({op_fill, 2'b00});
        cap_x4     = rcs_pkg::CMP_W'({r_cap, 2'b00});
        grow_hit   = cap_x4 <= (fill_x5 + rcs_pkg::CMP_W'(4));
        shrink_hit = fill_x5 <= rcs_pkg::CMP_W'(r_cap);

        grown_sum = {1'b0, r_cap} + {2'b00, r_cap[rcs_pkg::CNT_W-1:1]};
        if (grown_sum > {1'b0, rcs_pkg::CAP_MAX}) begin
            grown_cap = rcs_pkg::CAP_MAX;
        end else begin
            grown_cap = grown_sum[rcs_pkg::CNT_W-1:0];
        end

        push_addr = r_fill[rcs_pkg::ADDR_W-1:0];
        pop_addr  = op_fill[rcs_pkg::ADDR_W-1:0];

        n_fill  = op_fill;
        n_cap   = r_cap;
        n_grown = r_grown;
        if (cfg_beat) begin
            n_fill  = '0;
            n_cap   = rcs_pkg::cap_clamp(i_cfg_initial_capacity);
            n_grown = 1'b0;
        end else if (push_ok || pop_ok) begin
            if (grow_hit) begin
                n_cap   = grown_cap;
                n_grown = 1'b1;
            end else if (shrink_hit && r_grown) begin
                n_cap = {1'b0, r_cap[rcs_pkg::CNT_W-1:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_cap       <= rcs_pkg::CAP_RESET;
            r_grown     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill  <= n_fill;
            r_cap   <= n_cap;
            r_grown <= n_grown;
            if (in_beat) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; held while the output beat is stalled.
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_accepted <= push_ok || pop_ok;
            r_pop_ok   <= pop_ok;
            r_out_cap  <= n_cap;
            r_out_occ  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[push_addr] <= i_value;
        end
        if (pop_ok) begin
            r_rd_data <= r_mem[pop_addr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pop_value = r_pop_ok ? r_rd_data : '0;
    assign o_accepted  = r_accepted;
    assign o_capacity  = r_out_cap;
    assign o_occupancy = r_out_occ;

endmodule

>>> hw/rtl/rcs_checker.sv
// Port-level checks of the resizable stack, bound to its top level.
// Depends on rcs_pkg and the assertion macros of the defines header.
`include "resizable_capacity_stack_top_defines.svh"

module rcs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] o_pop_value,
    input logic               o_accepted,
    input logic [10:0]        o_capacity,
    input logic [10:0]        o_occupancy
);

    `RCS_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pop_value), "stalled result beat changed")
    `RCS_ASSERT(a_occ_le_cap, o_out_valid |-> o_occupancy <= o_capacity, "occupancy above capacity")
    `RCS_ASSERT(a_cap_range, o_out_valid |-> o_capacity != '0 && o_capacity <= rcs_pkg::CAP_MAX, "capacity out of range")
    `RCS_ASSERT(a_refused_zero, o_out_valid && !o_accepted |-> o_pop_value == '0, "refused operation returned a word")
    `RCS_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_out_valid, "result beat after reset")

endmodule

bind resizable_capacity_stack_top rcs_checker u_rcs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_pop_value (o_pop_value),
    .o_accepted  (o_accepted),
    .o_capacity  (o_capacity),
    .o_occupancy (o_occupancy)
);

>>> verif/resizable_capacity_stack_top_test.sv
// Self-checking testbench for the resizable-capacity stack: random push and pop beats are
// checked against a cycle-free model of the fill, capacity and resize rules.
// Depends on rcs_pkg and the resizable_capacity_stack_top RTL.
module resizable_capacity_stack_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        rcs_pkg::t_kind kind;
        rcs_pkg::t_word value;
    } t_stack_op;

    typedef struct {
        rcs_pkg::t_word  pop_value;
        logic            accepted;
        rcs_pkg::t_count capacity;
        rcs_pkg::t_count occupancy;
    } t_stack_result;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_kind = 1'b0;
    logic signed [31:0] i_value = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [31:0] o_pop_value;
    logic               o_accepted;
    logic [10:0]        o_capacity;
    logic [10:0]        o_occupancy;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [10:0]        i_cfg_initial_capacity = '0;

    resizable_capacity_stack_top u_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (i_in_valid),
        .o_in_ready             (o_in_ready),
        .i_kind                 (i_kind),
        .i_value                (i_value),
        .o_out_valid            (o_out_valid),
        .i_out_ready            (i_out_ready),
        .o_pop_value            (o_pop_value),
        .o_accepted             (o_accepted),
        .o_capacity             (o_capacity),
        .o_occupancy            (o_occupancy),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_initial_capacity (i_cfg_initial_capacity)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Model state of the stack.
    rcs_pkg::t_word  stack_words [rcs_pkg::MAX_CAPACITY];
    rcs_pkg::t_count depth_used;
    rcs_pkg::t_count cur_capacity;
    logic            grown_once;

    t_stack_op     pending_ops[$];
    t_stack_result expected_results[$];
    int unsigned   ops_issued = 0;
    int unsigned   results_seen = 0;
    int unsigned   fail_count = 0;
    int unsigned   idle_pct = 34;
    logic          in_beat_seen = 1'b0;
    logic          cfg_beat_seen = 1'b0;

    function automatic void restart_stack(input rcs_pkg::t_count size);
        depth_used = '0;
        grown_once = 1'b0;
        if (size == '0) begin
            cur_capacity = rcs_pkg::t_count'(1);
        end else if (size > rcs_pkg::t_count'(rcs_pkg::MAX_CAPACITY)) begin
            cur_capacity = rcs_pkg::t_count'(rcs_pkg::MAX_CAPACITY);
        end else begin
            cur_capacity = size;
        end
    endfunction

    function automatic void resize_after_op();
        rcs_pkg::t_cmp cap_w;
        rcs_pkg::t_cmp fill_w;
        rcs_pkg::t_cmp bigger;
        cap_w  = rcs_pkg::t_cmp'(cur_capacity);
        fill_w = rcs_pkg::t_cmp'(depth_used);
        if (fill_w >= (cap_w * 4) / 5) begin
            bigger = (cap_w * 3) / 2;
            if (bigger > rcs_pkg::t_cmp'(rcs_pkg::MAX_CAPACITY)) begin
                bigger = rcs_pkg::t_cmp'(rcs_pkg::MAX_CAPACITY);
            end
            cur_capacity = rcs_pkg::t_count'(bigger);
            grown_once   = 1'b1;
        end else if (fill_w <= cap_w / 5 && grown_once) begin
            cur_capacity = rcs_pkg::t_count'(cap_w / 2);
        end
    endfunction

    function automatic t_stack_result apply_stack_op(input rcs_pkg::t_kind kind,
                                                     input rcs_pkg::t_word value);
        t_stack_result r;
        r.pop_value = '0;
        r.accepted  = 1'b0;
        if (kind == rcs_pkg::KIND_PUSH) begin
            if (depth_used < cur_capacity
                && depth_used < rcs_pkg::t_count'(rcs_pkg::MAX_CAPACITY)) begin
                stack_words[rcs_pkg::t_addr'(depth_used)] = value;
                depth_used = depth_used + 1'b1;
                r.accepted = 1'b1;
                resize_after_op();
            end
        end else if (depth_used != '0) begin
            depth_used  = depth_used - 1'b1;
            r.pop_value = stack_words[rcs_pkg::t_addr'(depth_used)];
            r.accepted  = 1'b1;
            resize_after_op();
        end
        r.capacity  = cur_capacity;
        r.occupancy = depth_used;
        return r;
    endfunction

    // Driver: a new beat is offered only once the previous one was taken.
    always @(negedge i_clk) begin
        t_stack_op op;
        if (i_rst_n) begin
            if (!i_in_valid || in_beat_seen) begin
                if (pending_ops.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    op = pending_ops.pop_front();
                    i_in_valid <= 1'b1;
                    i_kind     <= op.kind;
                    i_value    <= op.value;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Monitor: checks result beats, then predicts from the input beat of this edge.
    always @(posedge i_clk) begin
        t_stack_result want;
        if (!i_rst_n) begin
            restart_stack(rcs_pkg::CAP_RESET);
            in_beat_seen  = 1'b0;
            cfg_beat_seen = 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected result beat: pop_value=%0d accepted=%0b cap=%0d occ=%0d",
                                 o_pop_value, o_accepted, o_capacity, o_occupancy);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (o_pop_value !== want.pop_value || o_accepted !== want.accepted ||
                        o_capacity !== want.capacity || o_occupancy !== want.occupancy) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch: pop_value exp %0d got %0d, accepted exp %0b got %0b",
                                     want.pop_value, o_pop_value, want.accepted, o_accepted);
                            $display("          capacity exp %0d got %0d, occupancy exp %0d got %0d",
                                     want.capacity, o_capacity, want.occupancy, o_occupancy);
                        end
                    end
                end
            end
            in_beat_seen = i_in_valid && o_in_ready;
            if (in_beat_seen) begin
                expected_results.push_back(apply_stack_op(rcs_pkg::t_kind'(i_kind), i_value));
            end
            cfg_beat_seen = i_cfg_valid && o_cfg_ready;
            if (cfg_beat_seen) begin
                restart_stack(i_cfg_initial_capacity);
            end
        end
    end

    function automatic rcs_pkg::t_word pick_word();
        rcs_pkg::t_word w;
        case ($urandom_range(9))
            0: w = rcs_pkg::t_word'(32'h7FFF_FFFF);
            1: w = rcs_pkg::t_word'(32'h8000_0000);
            2: w = '0;
            3: w = rcs_pkg::t_word'(32'hFFFF_FFFF);
            default: w = rcs_pkg::t_word'($urandom());
        endcase
        return w;
    endfunction

    task automatic queue_op(input rcs_pkg::t_kind kind, input rcs_pkg::t_word value);
        t_stack_op op;
        op.kind  = kind;
        op.value = value;
        pending_ops.push_back(op);
        ops_issued++;
    endtask

    // Push-heavy and pop-heavy bursts alternate so the fill sweeps up and down
    // through both resize thresholds.
    task automatic queue_mix(input int n);
        int push_pct;
        for (int i = 0; i < n; i++) begin
            push_pct = ((i / 40) % 2 == 0) ? 72 : 33;
            queue_op(($urandom_range(99) < push_pct) ? rcs_pkg::KIND_PUSH : rcs_pkg::KIND_POP,
                     pick_word());
        end
    endtask

    task automatic wait_drained();
        while (results_seen != ops_issued) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_capacity(input rcs_pkg::t_count size);
        wait_drained();
        i_cfg_valid            <= 1'b1;
        i_cfg_initial_capacity <= size;
        do begin
            @(negedge i_clk);
        end while (!cfg_beat_seen);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset capacity of ten: empty pop, extreme words, growth at four fifths,
        // then shrinking by halves on the way back down to empty.
        queue_op(rcs_pkg::KIND_POP, rcs_pkg::t_word'(32'h1234_5678));
        queue_op(rcs_pkg::KIND_PUSH, rcs_pkg::t_word'(32'h7FFF_FFFF));
        queue_op(rcs_pkg::KIND_PUSH, rcs_pkg::t_word'(32'h8000_0000));
        queue_op(rcs_pkg::KIND_PUSH, '0);
        queue_op(rcs_pkg::KIND_PUSH, rcs_pkg::t_word'(32'hFFFF_FFFF));
        queue_op(rcs_pkg::KIND_PUSH, rcs_pkg::t_word'(32'h5555_5555));
        queue_op(rcs_pkg::KIND_PUSH, rcs_pkg::t_word'(32'hAAAA_AAAA));
        queue_op(rcs_pkg::KIND_PUSH, rcs_pkg::t_word'(32'h0000_0001));
        queue_op(rcs_pkg::KIND_PUSH, rcs_pkg::t_word'(32'hFFFF_FFFE));
        for (int i = 0; i < 8; i++) begin
            queue_op(rcs_pkg::KIND_POP, pick_word());
        end
        queue_op(rcs_pkg::KIND_POP, rcs_pkg::t_word'(32'hFFFF_FFFF));

        // A zero size is taken as one: the second push is refused.
        write_capacity('0);
        queue_op(rcs_pkg::KIND_PUSH, rcs_pkg::t_word'(32'h8000_0001));
        queue_op(rcs_pkg::KIND_PUSH, rcs_pkg::t_word'(32'h7FFF_FFFE));
        queue_op(rcs_pkg::KIND_POP, '0);
        queue_op(rcs_pkg::KIND_POP, '0);
        queue_mix(60);

        // An oversized request is held at the depth.
        write_capacity(rcs_pkg::t_count'(11'h7FF));
        queue_mix(10);

        // From a size of 700 the growth at four fifths saturates at the depth; this
        // stretch runs with no idling on either side, then drains part of the fill.
        write_capacity(rcs_pkg::t_count'(700));
        idle_pct = 0;
        for (int i = 0; i < 570; i++) begin
            queue_op(rcs_pkg::KIND_PUSH, pick_word());
        end
        for (int i = 0; i < 20; i++) begin
            queue_op(rcs_pkg::KIND_POP, pick_word());
        end
        wait_drained();
        idle_pct = 34;

        write_capacity(rcs_pkg::t_count'(10));
        queue_mix(80);
        write_capacity(rcs_pkg::t_count'(3));
        queue_mix(40);
        write_capacity(rcs_pkg::t_count'(100));
        queue_mix(60);
        write_capacity(rcs_pkg::t_count'(1));
        queue_mix(20);
        write_capacity(rcs_pkg::t_count'(rcs_pkg::MAX_CAPACITY));
        queue_mix(30);

        wait_drained();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
